// ===== design/ym_frame_register_player_assert.svh =====
// Assertion macros used by the checker file of the frame register player.
`ifndef YM_FRAME_REGISTER_PLAYER_ASSERT_SVH
`define YM_FRAME_REGISTER_PLAYER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define YMFRP_ASSERT_SAME(label, clock, reset, ante, cons) \
  label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
    else $error("frame register player check failed");

// The consequent must hold in the cycle after the antecedent.
`define YMFRP_ASSERT_NEXT(label, clock, reset, ante, cons) \
  label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
    else $error("frame register player check failed");

`endif

// ===== design/ymfrp_pkg.sv =====
package ymfrp_pkg;

  localparam int ADDRESS_W   = 16;
  localparam int BYTE_W      = 8;
  localparam int CHIP_REG_W  = 4;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 16;
  localparam int COUNT_W     = 16;

  // Item kinds.
  localparam logic KIND_STORE = 1'b0;
  localparam logic KIND_TICK  = 1'b1;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] CFG_INTERLEAVED = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_BYTES = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_COUNT = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_LOOP_FRAME  = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_PASS_COUNT  = 3'd4;

  localparam logic [CHIP_REG_W-1:0] LAST_CHIP_REG  = 4'd13;
  localparam logic [CHIP_REG_W-1:0] SKIP_REGISTER  = 4'd13;
  localparam logic [CHIP_REG_W-1:0] MIXER_REGISTER = 4'd7;
  localparam logic [BYTE_W-1:0]     SKIP_MARK      = 8'hFF;
  localparam logic [BYTE_W-1:0]     SILENCE_VALUE  = 8'h3F;

  // Play position: frame index and remaining passes.
  typedef struct packed {
    logic [COUNT_W-1:0] frame;
    logic [COUNT_W-1:0] passes;
  } pos_t;

endpackage

// ===== design/ymfrp_stream_if.sv =====
interface ymfrp_item_if;
  import ymfrp_pkg::*;

  logic                 valid;
  logic                 ready;
  logic                 kind;
  logic [ADDRESS_W-1:0] address;
  logic [BYTE_W-1:0]    song_byte;

  modport source (output valid, kind, address, song_byte, input ready);
  modport sink   (input valid, kind, address, song_byte, output ready);
endinterface

interface ymfrp_write_if;
  import ymfrp_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CHIP_REG_W-1:0] chip_register;
  logic [BYTE_W-1:0]     register_value;
  logic                  last;

  modport source (output valid, chip_register, register_value, last, input ready);
  modport sink   (input valid, chip_register, register_value, last, output ready);
endinterface

// ===== design/ymfrp_ram.sv =====
module ymfrp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Read data holds while the port is not enabled.
  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

// ===== design/ym_frame_register_player.sv =====
// Channel   Dir  Payload                                  Handshake
// items     in   kind, address, song_byte                 valid / ready
// writes    out  chip_register, register_value, last      valid / ready
// cfg       in   cfg_index, cfg_data                      cfg_write, no wait
//
// A store item is written to song memory in the cycle it is taken. A tick
// settles the position, forms the frame address, does two memory reads and
// then sends one chip register write per song byte, as the single song memory
// port gives one byte per cycle; a tick after play has finished writes nothing.
// Reset is synchronous; song memory is not cleared. A stalled writes channel
// holds the sequencer; items are taken only while no tick is in progress.
// MEMORY_BYTES must be a power of two, so addresses wrap by truncation.
module ym_frame_register_player #(
  parameter int MEMORY_BYTES = 65536
) (
  input  logic                                   clk,
  input  logic                                   rst,
  ymfrp_item_if.sink                             items,
  ymfrp_write_if.source                          writes,
  input  logic                                   cfg_write,
  input  logic [ymfrp_pkg::CFG_INDEX_W-1:0]      cfg_index,
  input  logic [ymfrp_pkg::CFG_DATA_W-1:0]       cfg_data
);
  import ymfrp_pkg::*;

  localparam int ADDR_W = $clog2(MEMORY_BYTES);

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_ADDR    = 3'd1;
  localparam logic [2:0] S_PRE     = 3'd2;
  localparam logic [2:0] S_FIRST   = 3'd3;
  localparam logic [2:0] S_EMIT    = 3'd4;
  localparam logic [2:0] S_SILENCE = 3'd5;

  logic               interleaved;
  logic [4:0]         frame_bytes;
  logic [COUNT_W-1:0] frame_count;
  logic [COUNT_W-1:0] loop_frame;
  logic [COUNT_W-1:0] pass_count;

  logic [COUNT_W-1:0] frame_index;
  logic [COUNT_W-1:0] passes_left;
  logic               started;
  logic               finished;

  logic [2:0]            state;
  logic [CHIP_REG_W-1:0] reg_num;
  logic [ADDR_W-1:0]     addr;
  logic [BYTE_W-1:0]     byte13;

  logic                  wr_valid;
  logic [CHIP_REG_W-1:0] wr_register;
  logic [BYTE_W-1:0]     wr_value;
  logic                  wr_last;
  logic                  wr_load;

  logic               ram_en;
  logic               ram_we;
  logic [ADDR_W-1:0]  ram_addr;
  logic [BYTE_W-1:0]  ram_q;

  pos_t               pre;
  pos_t               post;
  logic               done_after;
  logic               slot_free;
  logic               tick_go;
  logic [31:0]        step32;
  logic [31:0]        prod32;
  logic [31:0]        base32;
  logic [31:0]        addr13_32;
  logic [31:0]        addr_inc32;
  logic [31:0]        store32;

  // End-of-pass handling: wrap to the loop frame, or run out of passes.
  function automatic pos_t settle(input logic [COUNT_W-1:0] fi,
                                  input logic [COUNT_W-1:0] pl,
                                  input logic [COUNT_W-1:0] fc,
                                  input logic [COUNT_W-1:0] lf);
    pos_t p;
    p.frame  = fi;
    p.passes = pl;
    if (pl != '0 && fi >= fc) begin
      p.frame  = lf;
      p.passes = (lf >= fc) ? '0 : pl - 1'b1;
    end
    return p;
  endfunction

  always_comb begin
    pre = settle(started ? frame_index : '0, started ? passes_left : pass_count,
                 frame_count, loop_frame);
    post = settle(frame_index + 1'b1, passes_left, frame_count, loop_frame);
  end

  assign done_after = (post.passes == '0);
  assign slot_free  = !wr_valid || writes.ready;
  assign tick_go    = items.valid && items.kind == KIND_TICK && !finished;

  // A new write enters the output register in this cycle.
  assign wr_load = slot_free &&
                   ((state == S_EMIT && (reg_num != LAST_CHIP_REG || byte13 != SKIP_MARK)) ||
                    state == S_SILENCE);

  assign step32     = interleaved ? 32'(frame_count) : 32'd1;
  assign prod32     = 32'(frame_index) * 32'(frame_bytes);
  assign base32     = interleaved ? 32'(frame_index) : prod32;
  assign addr13_32  = 32'(addr) + step32 * 32'(SKIP_REGISTER);
  assign addr_inc32 = 32'(addr) + step32;
  assign store32    = 32'(items.address);

  always_comb begin
    ram_en   = 1'b0;
    ram_we   = 1'b0;
    ram_addr = addr;
    case (state)
      S_IDLE: begin
        if (items.valid && items.kind == KIND_STORE) begin
          ram_en   = 1'b1;
          ram_we   = 1'b1;
          ram_addr = store32[ADDR_W-1:0];
        end
      end
      S_PRE: begin
        ram_en   = 1'b1;
        ram_addr = addr13_32[ADDR_W-1:0];
      end
      S_FIRST: begin
        ram_en = 1'b1;
      end
      S_EMIT: begin
        // Fetch the next byte while the current one goes out.
        if (slot_free && reg_num < LAST_CHIP_REG - 4'd1) begin
          ram_en   = 1'b1;
          ram_addr = addr_inc32[ADDR_W-1:0];
        end
      end
      default: begin
        ram_en = 1'b0;
      end
    endcase
  end

  ymfrp_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (MEMORY_BYTES)
  ) u_song_ram (
    .clk   (clk),
    .en    (ram_en),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (items.song_byte),
    .rdata (ram_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      interleaved <= 1'b0;
      frame_bytes <= 5'd16;
      frame_count <= '0;
      loop_frame  <= '0;
      pass_count  <= 16'd1;
      frame_index <= '0;
      passes_left <= '0;
      started     <= 1'b0;
      finished    <= 1'b0;
      state       <= S_IDLE;
      reg_num     <= '0;
      wr_valid    <= 1'b0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          CFG_INTERLEAVED: interleaved <= cfg_data[0];
          CFG_FRAME_BYTES: frame_bytes <= cfg_data[4:0];
          CFG_FRAME_COUNT: frame_count <= cfg_data;
          CFG_LOOP_FRAME:  loop_frame  <= cfg_data;
          CFG_PASS_COUNT:  pass_count  <= cfg_data;
          default: ;
        endcase
      end

      if (wr_load) begin
        wr_valid <= 1'b1;
      end else if (writes.ready) begin
        wr_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (tick_go) begin
            started     <= 1'b1;
            frame_index <= pre.frame;
            passes_left <= pre.passes;
            if (pre.passes == '0) begin
              finished <= 1'b1;
              state    <= S_SILENCE;
            end else begin
              state <= S_ADDR;
            end
          end
        end
        S_ADDR: begin
          addr  <= base32[ADDR_W-1:0];
          state <= S_PRE;
        end
        S_PRE: begin
          state <= S_FIRST;
        end
        S_FIRST: begin
          // Register 13 is read first so the last flag is known in time.
          byte13  <= ram_q;
          reg_num <= '0;
          state   <= S_EMIT;
        end
        S_EMIT: begin
          if (slot_free) begin
            if (reg_num != LAST_CHIP_REG) begin
              wr_register <= reg_num;
              wr_value    <= ram_q;
              wr_last     <= (reg_num == LAST_CHIP_REG - 4'd1) &&
                             byte13 == SKIP_MARK && !done_after;
              if (reg_num == LAST_CHIP_REG - 4'd1) begin
                reg_num <= LAST_CHIP_REG;
              end else begin
                reg_num <= reg_num + 4'd1;
                addr    <= addr_inc32[ADDR_W-1:0];
              end
            end else begin
              if (byte13 != SKIP_MARK) begin
                wr_register <= SKIP_REGISTER;
                wr_value    <= byte13;
                wr_last     <= !done_after;
              end
              frame_index <= post.frame;
              passes_left <= post.passes;
              if (done_after) begin
                finished <= 1'b1;
                state    <= S_SILENCE;
              end else begin
                state <= S_IDLE;
              end
            end
          end
        end
        S_SILENCE: begin
          if (slot_free) begin
            wr_register <= MIXER_REGISTER;
            wr_value    <= SILENCE_VALUE;
            wr_last     <= 1'b1;
            state       <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign items.ready           = (state == S_IDLE);
  assign writes.valid          = wr_valid;
  assign writes.chip_register  = wr_register;
  assign writes.register_value = wr_value;
  assign writes.last           = wr_last;

endmodule

// ===== design/ymfrp_checker.sv =====
`include "ym_frame_register_player_assert.svh"

module ymfrp_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              items_valid,
  input logic                              items_ready,
  input logic                              items_kind,
  input logic                              writes_valid,
  input logic                              writes_ready,
  input logic [ymfrp_pkg::CHIP_REG_W-1:0]  writes_register,
  input logic [ymfrp_pkg::BYTE_W-1:0]      writes_value,
  input logic                              writes_last
);
  import ymfrp_pkg::*;

  logic                         store_taken;
  logic                         write_stalled;
  logic                         reg13_write;
  logic [CHIP_REG_W+BYTE_W:0]   write_payload;

  assign store_taken   = items_valid && items_ready && items_kind == KIND_STORE;
  assign write_stalled = writes_valid && !writes_ready;
  assign reg13_write   = writes_valid && writes_register == SKIP_REGISTER;
  assign write_payload = {writes_register, writes_value, writes_last};

  // A write that is not the last of its tick means the tick is still running.
  `YMFRP_ASSERT_SAME(busy_until_last, clk, rst, writes_valid && !writes_last, !items_ready)

  // A store item never produces a write.
  `YMFRP_ASSERT_NEXT(store_is_silent, clk, rst, store_taken && !writes_valid, !writes_valid)

  // Register 13 carrying the skip mark is never written.
  `YMFRP_ASSERT_SAME(skip_mark_dropped, clk, rst, reg13_write, writes_value != SKIP_MARK)

  // A stalled write keeps its payload.
  `YMFRP_ASSERT_NEXT(stall_holds, clk, rst, write_stalled, writes_valid && $stable(write_payload))

endmodule

bind ym_frame_register_player ymfrp_checker u_ymfrp_checker (
  .clk             (clk),
  .rst             (rst),
  .items_valid     (items.valid),
  .items_ready     (items.ready),
  .items_kind      (items.kind),
  .writes_valid    (writes.valid),
  .writes_ready    (writes.ready),
  .writes_register (writes.chip_register),
  .writes_value    (writes.register_value),
  .writes_last     (writes.last)
);
